// ----- hw/rtl/cylinder_mesh_vertex_generator_top_macros.svh -----
// Assertion macros for the cylinder mesh vertex generator checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CYLINDER_MESH_VERTEX_GENERATOR_TOP_MACROS_SVH
`define CYLINDER_MESH_VERTEX_GENERATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMVG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cmvg_pkg.sv -----
// Shared types, constants and helper functions of the cylinder mesh vertex generator.
// Used by cmvg_front, cmvg_rim, cmvg_back and the top level; depends on nothing else.
package cmvg_pkg;

  localparam int MAX_FACES     = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int PHASE_W       = 32;
  localparam int DIV_STAGES    = PHASE_W;
  localparam int FACE_W        = $clog2(MAX_FACES);
  localparam int N_W           = $clog2(MAX_FACES) + 1;
  localparam int FC_W          = 11;
  localparam int RES_DEPTH     = 16;
  localparam int RES_AW        = $clog2(RES_DEPTH);
  localparam int CRED_W        = $clog2(RES_DEPTH + 1);
  localparam int ITEM_DEPTH    = 4;
  localparam int ITEM_AW       = $clog2(ITEM_DEPTH);

  localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
  localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;
  localparam logic signed [33:0] SAT_HI     = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_LO     = 34'sh3_8000_0000;

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    ACT_TOP    = 2'd0,
    ACT_BOTTOM = 2'd1,
    ACT_SIDE   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_FACES  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_CX     = 3'd3,
    CFG_CY     = 3'd4,
    CFG_CZ     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [FC_W-1:0] face_count;
    logic [30:0]     height;
    logic [30:0]     radius;
    logic [31:0]     cx;
    logic [31:0]     cy;
    logic [31:0]     cz;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    logic              bad;
    logic [FACE_W-1:0] i;
    logic [FACE_W-1:0] j;
  } item_t;

  typedef struct packed {
    action_e action;
    logic    bad;
    logic    last;
  } tag_t;

  typedef struct packed {
    logic [FACE_W-1:0] idx;
    tag_t              tag;
  } pt_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
    tag_t        tag;
  } rim_t;

  typedef struct packed {
    action_e     action;
    logic        bad;
    logic [31:0] x0;
    logic [31:0] z0;
    logic [31:0] x1;
    logic [31:0] z1;
  } pair_t;

  function automatic logic [N_W-1:0] eff_faces(input logic [FC_W-1:0] fc);
    logic [N_W-1:0] n;
    n = N_W'(fc);
    if (n < N_W'(3)) begin
      n = N_W'(3);
    end else if (n > N_W'(MAX_FACES)) begin
      n = N_W'(MAX_FACES);
    end
    return n;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cmvg_front.sv -----
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on cmvg_pkg.
module cmvg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmvg_pkg::cfg_t      cfg_i,
  input  logic                start_i,
  input  logic [1:0]          action_i,
  input  logic [cmvg_pkg::FACE_W-1:0] face_index_i,
  output logic                busy_o,
  output logic                item_valid_o,
  output cmvg_pkg::item_t     item_o,
  input  logic                item_pop_i
);
  import cmvg_pkg::*;

  item_t          mem_q [ITEM_DEPTH];
  logic [ITEM_AW:0] wp_q, rp_q;
  logic [N_W-1:0] n_eff, nxt;
  logic           full, empty, push, bad;
  item_t          item_d;

  assign n_eff = eff_faces(cfg_i.face_count);
  assign bad   = N_W'(face_index_i) >= n_eff;
  assign nxt   = N_W'(face_index_i) + N_W'(1);

  always_comb begin
    item_d.action = action_e'(action_i);
    item_d.bad    = bad;
    item_d.i      = bad ? '0 : face_index_i;
    item_d.j      = (bad || nxt == n_eff) ? '0 : nxt[FACE_W-1:0];
  end

  assign full   = (wp_q[ITEM_AW] != rp_q[ITEM_AW]) &&
                  (wp_q[ITEM_AW-1:0] == rp_q[ITEM_AW-1:0]);
  assign empty  = wp_q == rp_q;
  assign busy_o = full;
  assign push   = start_i && !full && (action_e'(action_i) != ACT_NONE);

  assign item_valid_o = !empty;
  assign item_o       = mem_q[rp_q[ITEM_AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (item_pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q[ITEM_AW-1:0]] <= item_d;
    end
  end

endmodule

// ----- hw/rtl/cmvg_rim.sv -----
// Rim point pipeline: phase divider, CORDIC, quadrant fix, radius scaling and offset.
// Depends on cmvg_pkg; accepts one point per cycle.
module cmvg_rim (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmvg_pkg::cfg_t cfg_i,
  input  logic           pt_valid_i,
  input  cmvg_pkg::pt_t  pt_i,
  output logic           res_valid_o,
  output cmvg_pkg::rim_t res_o
);
  import cmvg_pkg::*;

  logic [N_W-1:0] n_eff;

  logic               dv_q [DIV_STAGES+1];
  tag_t               dt_q [DIV_STAGES+1];
  logic [N_W-1:0]     dr_q [DIV_STAGES+1];
  logic [PHASE_W-1:0] dq_q [DIV_STAGES+1];

  logic               cv_q [CORDIC_STAGES+1];
  tag_t               ct_q [CORDIC_STAGES+1];
  logic [1:0]         cq_q [CORDIC_STAGES+1];
  logic signed [31:0] cx_q [CORDIC_STAGES+1];
  logic signed [31:0] cy_q [CORDIC_STAGES+1];
  logic signed [31:0] cz_q [CORDIC_STAGES+1];

  logic               qv_q, mv_q, ov_q, av_q;
  tag_t               qt_q, mt_q, ot_q, at_q;
  logic signed [31:0] qc_q, qs_q, fc, fs;
  logic signed [63:0] px_q, pz_q, prod_x, prod_z, sum_x, sum_z;
  logic signed [32:0] ox_q, oz_q;
  logic signed [31:0] rad_s;
  logic [31:0]        ax_q, az_q;

  assign n_eff = eff_faces(cfg_i.face_count);
  assign rad_s = $signed({1'b0, cfg_i.radius});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= pt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q[0] <= pt_i.tag;
    dr_q[0] <= N_W'(pt_i.idx);
    dq_q[0] <= '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [N_W:0] dbl, sub;
    logic         ge;
    assign dbl = {dr_q[k], 1'b0};
    assign ge  = dbl >= {1'b0, n_eff};
    assign sub = dbl - {1'b0, n_eff};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      dt_q[k+1] <= dt_q[k];
      dr_q[k+1] <= ge ? sub[N_W-1:0] : dbl[N_W-1:0];
      dq_q[k+1] <= {dq_q[k][PHASE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= dv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    ct_q[0] <= dt_q[DIV_STAGES];
    cq_q[0] <= dq_q[DIV_STAGES][PHASE_W-1:PHASE_W-2];
    cx_q[0] <= GAIN_Q30;
    cy_q[0] <= '0;
    cz_q[0] <= $signed({2'b00, dq_q[DIV_STAGES][PHASE_W-3:0]});
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    logic signed [31:0] dx, dy, at;
    logic               pos;
    assign dx  = cy_q[k] >>> k;
    assign dy  = cx_q[k] >>> k;
    assign at  = $signed(ATAN_TURN[k]);
    assign pos = !cz_q[k][31];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else begin
        cv_q[k+1] <= cv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      ct_q[k+1] <= ct_q[k];
      cq_q[k+1] <= cq_q[k];
      cx_q[k+1] <= pos ? cx_q[k] - dx : cx_q[k] + dx;
      cy_q[k+1] <= pos ? cy_q[k] + dy : cy_q[k] - dy;
      cz_q[k+1] <= pos ? cz_q[k] - at : cz_q[k] + at;
    end
  end

  always_comb begin
    case (cq_q[CORDIC_STAGES])
      2'd1: begin
        fc = -cy_q[CORDIC_STAGES];
        fs = cx_q[CORDIC_STAGES];
      end
      2'd2: begin
        fc = -cx_q[CORDIC_STAGES];
        fs = -cy_q[CORDIC_STAGES];
      end
      2'd3: begin
        fc = cy_q[CORDIC_STAGES];
        fs = -cx_q[CORDIC_STAGES];
      end
      default: begin
        fc = cx_q[CORDIC_STAGES];
        fs = cy_q[CORDIC_STAGES];
      end
    endcase
  end

  assign prod_x = 64'(rad_s) * 64'(qc_q);
  assign prod_z = 64'(rad_s) * 64'(qs_q);
  assign sum_x  = px_q + ROUND_HALF - 64'(px_q[63]);
  assign sum_z  = pz_q + ROUND_HALF - 64'(pz_q[63]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= 1'b0;
      mv_q <= 1'b0;
      ov_q <= 1'b0;
      av_q <= 1'b0;
    end else begin
      qv_q <= cv_q[CORDIC_STAGES];
      mv_q <= qv_q;
      ov_q <= mv_q;
      av_q <= ov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qt_q <= ct_q[CORDIC_STAGES];
    qc_q <= fc;
    qs_q <= fs;
    mt_q <= qt_q;
    px_q <= prod_x;
    pz_q <= prod_z;
    ot_q <= mt_q;
    ox_q <= sum_x[62:30];
    oz_q <= sum_z[62:30];
    at_q <= ot_q;
    ax_q <= sat32(34'($signed(cfg_i.cx)) + 34'(ox_q));
    az_q <= sat32(34'($signed(cfg_i.cz)) + 34'(oz_q));
  end

  assign res_valid_o = av_q;
  assign res_o.x     = ax_q;
  assign res_o.z     = az_q;
  assign res_o.tag   = at_q;

endmodule

// ----- hw/rtl/cmvg_back.sv -----
// Back end: issues rim points, pairs the results, buffers them and emits the vertices.
// Depends on cmvg_pkg and drives the rim pipeline cmvg_rim.
module cmvg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmvg_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  cmvg_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            pt_valid_o,
  output cmvg_pkg::pt_t   pt_o,
  input  logic            res_valid_i,
  input  cmvg_pkg::rim_t  res_i,
  output logic            vert_valid_o,
  output logic [31:0]     vert_x_o,
  output logic [31:0]     vert_y_o,
  output logic [31:0]     vert_z_o,
  output logic            polygon_end_o,
  output logic            bad_index_o
);
  import cmvg_pkg::*;

  logic              second_q, first;
  logic [CRED_W-1:0] cred_q;
  logic [31:0]       x0_q, z0_q;
  pair_t             mem_q [RES_DEPTH];
  logic [RES_AW:0]   wp_q, rp_q;
  logic [1:0]        step_q;
  logic              empty, last, done;
  pair_t             head;
  logic [29:0]       half;
  logic [31:0]       ytop, ybot, vx, vy, vz;
  logic              vv_q, ve_q, vb_q;
  logic [31:0]       vx_q, vy_q, vz_q;

  assign first      = item_valid_i && !second_q && (cred_q != CRED_W'(RES_DEPTH));
  assign item_pop_o = second_q;
  assign pt_valid_o = first || second_q;
  assign pt_o.idx   = second_q ? item_i.j : item_i.i;
  assign pt_o.tag   = '{action: item_i.action, bad: item_i.bad, last: second_q};

  assign empty = wp_q == rp_q;
  assign head  = mem_q[rp_q[RES_AW-1:0]];
  assign half  = cfg_i.height[30:1];
  assign ytop  = sat32(34'($signed(cfg_i.cy)) + 34'(half));
  assign ybot  = sat32(34'($signed(cfg_i.cy)) - 34'(half));

  always_comb begin
    vx   = '0;
    vy   = '0;
    vz   = '0;
    last = 1'b1;
    if (!head.bad) begin
      case (head.action)
        ACT_SIDE: begin
          vy   = (step_q[1]) ? ytop : ybot;
          vx   = (step_q == 2'd1 || step_q == 2'd2) ? head.x1 : head.x0;
          vz   = (step_q == 2'd1 || step_q == 2'd2) ? head.z1 : head.z0;
          last = step_q == 2'd3;
        end
        default: begin
          vy   = (head.action == ACT_TOP) ? ytop : ybot;
          vx   = (step_q == 2'd0) ? head.x0 : (step_q == 2'd1) ? head.x1 : cfg_i.cx;
          vz   = (step_q == 2'd0) ? head.z0 : (step_q == 2'd1) ? head.z1 : cfg_i.cz;
          last = step_q == 2'd2;
        end
      endcase
    end
  end

  assign done = !empty && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      cred_q   <= '0;
      wp_q     <= '0;
      rp_q     <= '0;
      step_q   <= '0;
      vv_q     <= 1'b0;
    end else begin
      second_q <= first;
      cred_q   <= cred_q + CRED_W'(first) - CRED_W'(done);
      if (res_valid_i && res_i.tag.last) begin
        wp_q <= wp_q + 1'b1;
      end
      if (done) begin
        rp_q   <= rp_q + 1'b1;
        step_q <= '0;
      end else if (!empty) begin
        step_q <= step_q + 2'd1;
      end
      vv_q <= !empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && !res_i.tag.last) begin
      x0_q <= res_i.x;
      z0_q <= res_i.z;
    end
    if (res_valid_i && res_i.tag.last) begin
      mem_q[wp_q[RES_AW-1:0]] <= '{action: res_i.tag.action, bad: res_i.tag.bad,
                                   x0: x0_q, z0: z0_q, x1: res_i.x, z1: res_i.z};
    end
    vx_q <= vx;
    vy_q <= vy;
    vz_q <= vz;
    ve_q <= last;
    vb_q <= head.bad;
  end

  assign vert_valid_o  = vv_q;
  assign vert_x_o      = vx_q;
  assign vert_y_o      = vy_q;
  assign vert_z_o      = vz_q;
  assign polygon_end_o = ve_q;
  assign bad_index_o   = vb_q;

endmodule

// ----- hw/rtl/cylinder_mesh_vertex_generator_top.sv -----
// Top level of the cylinder mesh vertex generator: configuration registers and wiring.
// Depends on cmvg_pkg, cmvg_front, cmvg_rim and cmvg_back.
//
// A command is taken whenever busy is low, one per cycle, into a four-entry queue. The
// vertices leave on a single output port at one per cycle, so a side quad gives four
// vertices, a cap triangle three, a bad face index one, and an ignored action code none.
// Each point passes the 32-stage phase divider, the 16-stage CORDIC, the quadrant fix,
// the scaling and the offset registers; up to 16 polygons can be in flight.
// Vertices are shown for one cycle with vert_valid_o and cannot be held off by the receiver.
module cylinder_mesh_vertex_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [9:0]  face_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        vert_valid_o,
  output logic [31:0] vert_x_o,
  output logic [31:0] vert_y_o,
  output logic [31:0] vert_z_o,
  output logic        polygon_end_o,
  output logic        bad_index_o
);
  import cmvg_pkg::*;

  cfg_t  cfg_q;
  logic  item_valid, item_pop, pt_valid, res_valid;
  item_t item;
  pt_t   pt;
  rim_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.face_count <= FC_W'(8);
      cfg_q.height     <= 31'd65536;
      cfg_q.radius     <= 31'd65536;
      cfg_q.cx         <= '0;
      cfg_q.cy         <= '0;
      cfg_q.cz         <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FACES:  cfg_q.face_count <= cfg_data_i[FC_W-1:0];
        CFG_HEIGHT: cfg_q.height     <= cfg_data_i[30:0];
        CFG_RADIUS: cfg_q.radius     <= cfg_data_i[30:0];
        CFG_CX:     cfg_q.cx         <= cfg_data_i;
        CFG_CY:     cfg_q.cy         <= cfg_data_i;
        CFG_CZ:     cfg_q.cz         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cmvg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start),
    .action_i     (action_i),
    .face_index_i (face_index_i),
    .busy_o       (busy),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  cmvg_rim u_rim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pt_valid_i  (pt_valid),
    .pt_i        (pt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cmvg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .pt_valid_o    (pt_valid),
    .pt_o          (pt),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .vert_valid_o  (vert_valid_o),
    .vert_x_o      (vert_x_o),
    .vert_y_o      (vert_y_o),
    .vert_z_o      (vert_z_o),
    .polygon_end_o (polygon_end_o),
    .bad_index_o   (bad_index_o)
  );

endmodule

// ----- hw/rtl/cmvg_checker.sv -----
// Port-level checker for the cylinder mesh vertex generator, bound to its top level.
// Depends on cylinder_mesh_vertex_generator_top_macros.svh.
`include "cylinder_mesh_vertex_generator_top_macros.svh"

module cmvg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        vert_valid_i,
  input logic [31:0] vert_x_i,
  input logic [31:0] vert_y_i,
  input logic [31:0] vert_z_i,
  input logic        polygon_end_i,
  input logic        bad_index_i
);

  `CMVG_ASSERT_SAME(a_bad_ends, vert_valid_i && bad_index_i, polygon_end_i, "bad face not single")
  `CMVG_ASSERT_SAME(a_bad_zero, vert_valid_i && bad_index_i, vert_x_i == 32'd0 && vert_y_i == 32'd0 && vert_z_i == 32'd0, "bad face vertex not zero")
  `CMVG_ASSERT_NEXT(a_poly_run, vert_valid_i && !polygon_end_i, vert_valid_i, "polygon interrupted")
  `CMVG_ASSERT_NEXT(a_poly_ok, vert_valid_i && !polygon_end_i, !bad_index_i, "bad flag inside polygon")

endmodule

bind cylinder_mesh_vertex_generator_top cmvg_checker u_cmvg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .vert_valid_i  (vert_valid_o),
  .vert_x_i      (vert_x_o),
  .vert_y_i      (vert_y_o),
  .vert_z_i      (vert_z_o),
  .polygon_end_i (polygon_end_o),
  .bad_index_i   (bad_index_o)
);
